>>> sv/sphere_mesh_generator_assert.svh
// ----------------------------------------------------------------------------
// Sphere mesh generator assertion macros
// Concurrent check wrappers on clock with reset disable.
// ----------------------------------------------------------------------------
`ifndef SPHERE_MESH_GENERATOR_ASSERT_SVH
`define SPHERE_MESH_GENERATOR_ASSERT_SVH

// same-cycle implication
`define SMG_ASSERT_SAME(label, pre, post, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error(msg);

// next-cycle implication
`define SMG_ASSERT_NEXT(label, pre, post, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error(msg);

`endif

>>> sv/sphmg_pkg.sv
// ----------------------------------------------------------------------------
// Sphere mesh generator package
// Shared types and constants for the front end, queue and back end.
// ----------------------------------------------------------------------------
package sphmg_pkg;

   localparam int CSR_IW = 8;
   localparam int CSR_DW = 16;

   localparam logic [CSR_IW-1:0] REG_RING_COUNT    = 8'd0;
   localparam logic [CSR_IW-1:0] REG_SEGMENT_COUNT = 8'd1;
   localparam logic [CSR_IW-1:0] REG_POLAR_STEP    = 8'd2;
   localparam logic [CSR_IW-1:0] REG_AZIMUTH_STEP  = 8'd3;

   localparam logic [8:0]  RESET_RING_COUNT    = 9'd16;
   localparam logic [8:0]  RESET_SEGMENT_COUNT = 9'd16;
   localparam logic [15:0] RESET_POLAR_STEP    = 16'd2048;
   localparam logic [15:0] RESET_AZIMUTH_STEP  = 16'd4096;

   localparam logic [15:0] QUARTER_TURN = 16'h4000;

   localparam int Q_DEPTH = 4;
   localparam int Q_AW    = 2;

   localparam int LANE_LATENCY = 7;

   localparam logic signed [32:0] COEF_A1 = 33'sd1686629713;
   localparam logic signed [32:0] COEF_A3 = -33'sd693598668;
   localparam logic signed [32:0] COEF_A5 = 33'sd85569306;
   localparam logic signed [32:0] COEF_A7 = -33'sd5026995;
   localparam logic signed [32:0] COEF_A9 = 33'sd172272;

   typedef struct packed {
      logic [5:0][16:0] idx;
      logic             done;
   } side_type;

   typedef struct packed {
      logic [15:0] theta;
      logic [15:0] phi;
      side_type    side;
   } entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_stat_type;

endpackage

>>> sv/sphmg_front.sv
// ----------------------------------------------------------------------------
// Sphere mesh generator front end
// Holds configuration and grid counters, forms angles and quad indices.
// ----------------------------------------------------------------------------
module sphmg_front #(
   parameter int MAX_RINGS    = 256,
   parameter int MAX_SEGMENTS = 256
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic                           restart,
   output logic                           req_ready,
   input  logic                           csr_valid,
   input  logic [sphmg_pkg::CSR_IW-1:0]   csr_index,
   input  logic [sphmg_pkg::CSR_DW-1:0]   csr_data,
   input  sphmg_pkg::q_stat_type          q_stat,
   output logic                           push,
   output sphmg_pkg::entry_type           push_entry
);
   import sphmg_pkg::*;

   logic [8:0]  ring_count_ff, segment_count_ff;
   logic [15:0] polar_step_ff, azimuth_step_ff;
   logic [7:0]  ring_index_ff, point_index_ff, ring_index_in, point_index_in;
   logic [15:0] polar_phase_ff, azimuth_phase_ff, polar_phase_in, azimuth_phase_in;

   logic [8:0]  rc, sc;
   logic [7:0]  ri, pi;
   logic [15:0] pph, aph, theta, phi;
   logic        last_point, last_ring;
   logic [16:0] base, next, base_p, next_p;

   assign req_ready = !q_stat.full;
   assign push      = req_valid && req_ready;

   always_comb begin
      rc = (ring_count_ff == 9'd0) ? 9'd1 :
           (ring_count_ff > 9'(MAX_RINGS)) ? 9'(MAX_RINGS) : ring_count_ff;
      sc = (segment_count_ff == 9'd0) ? 9'd1 :
           (segment_count_ff > 9'(MAX_SEGMENTS)) ? 9'(MAX_SEGMENTS) : segment_count_ff;
      ri  = restart ? 8'd0 : ring_index_ff;
      pi  = restart ? 8'd0 : point_index_ff;
      pph = restart ? 16'd0 : polar_phase_ff;
      aph = restart ? 16'd0 : azimuth_phase_ff;
      theta = pph + polar_step_ff;
      phi   = aph + azimuth_step_ff;
      last_point = ({1'b0, pi} + 9'd1) >= sc;
      last_ring  = ({1'b0, ri} + 9'd1) >= rc;
      base   = {9'd0, ri} * {8'd0, sc};
      next   = base + {8'd0, sc};
      base_p = base + {9'd0, pi};
      next_p = next + {9'd0, pi};
   end

   always_comb begin
      push_entry.theta       = theta;
      push_entry.phi         = phi;
      push_entry.side.done   = last_point && last_ring;
      push_entry.side.idx[0] = base_p;
      push_entry.side.idx[2] = next_p;
      if (last_point) begin
         push_entry.side.idx[1] = base;
         push_entry.side.idx[3] = base;
         push_entry.side.idx[4] = next;
         push_entry.side.idx[5] = next_p;
      end else begin
         push_entry.side.idx[1] = base_p + 17'd1;
         push_entry.side.idx[3] = base_p + 17'd1;
         push_entry.side.idx[4] = next_p;
         push_entry.side.idx[5] = next_p + 17'd1;
      end
   end

   always_comb begin
      ring_index_in    = ring_index_ff;
      point_index_in   = point_index_ff;
      polar_phase_in   = polar_phase_ff;
      azimuth_phase_in = azimuth_phase_ff;
      if (push) begin
         if (last_point) begin
            point_index_in   = 8'd0;
            azimuth_phase_in = 16'd0;
            if (last_ring) begin
               ring_index_in  = 8'd0;
               polar_phase_in = 16'd0;
            end else begin
               ring_index_in  = ri + 8'd1;
               polar_phase_in = theta;
            end
         end else begin
            ring_index_in    = ri;
            polar_phase_in   = pph;
            point_index_in   = pi + 8'd1;
            azimuth_phase_in = phi;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ring_index_ff    <= '0;
         point_index_ff   <= '0;
         polar_phase_ff   <= '0;
         azimuth_phase_ff <= '0;
      end else begin
         ring_index_ff    <= ring_index_in;
         point_index_ff   <= point_index_in;
         polar_phase_ff   <= polar_phase_in;
         azimuth_phase_ff <= azimuth_phase_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ring_count_ff    <= RESET_RING_COUNT;
         segment_count_ff <= RESET_SEGMENT_COUNT;
         polar_step_ff    <= RESET_POLAR_STEP;
         azimuth_step_ff  <= RESET_AZIMUTH_STEP;
      end else if (csr_valid) begin
         unique case (csr_index)
            REG_RING_COUNT:    ring_count_ff    <= csr_data[8:0];
            REG_SEGMENT_COUNT: segment_count_ff <= csr_data[8:0];
            REG_POLAR_STEP:    polar_step_ff    <= csr_data;
            REG_AZIMUTH_STEP:  azimuth_step_ff  <= csr_data;
            default: ;
         endcase
      end
   end

endmodule

>>> sv/sphmg_queue.sv
// ----------------------------------------------------------------------------
// Sphere mesh generator point queue
// Short first-in first-out buffer between front end and back end.
// ----------------------------------------------------------------------------
module sphmg_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  sphmg_pkg::entry_type  push_entry,
   input  logic                  pop,
   output sphmg_pkg::entry_type  head,
   output sphmg_pkg::q_stat_type q_stat
);
   import sphmg_pkg::*;

   entry_type         mem [Q_DEPTH];
   logic [Q_AW-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [Q_AW:0]     count_ff, count_in;

   assign head         = mem[rd_ptr_ff];
   assign q_stat.full  = count_ff == (Q_AW+1)'(Q_DEPTH);
   assign q_stat.empty = count_ff == '0;

   always_comb begin
      count_in = count_ff;
      if (push && !pop) count_in = count_ff + 1'b1;
      else if (pop && !push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (push) mem[wr_ptr_ff] <= push_entry;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (pop) rd_ptr_ff <= rd_ptr_ff + 1'b1;
         count_ff <= count_in;
      end
   end

endmodule

>>> sv/sphmg_sine.sv
// ----------------------------------------------------------------------------
// Sphere mesh generator sine lane
// Pipelined odd polynomial sine of a 16-bit phase, Q1.15 result.
// ----------------------------------------------------------------------------
module sphmg_sine (
   input  logic               clock,
   input  logic               enable,
   input  logic [15:0]        phase,
   output logic signed [15:0] sine
);
   import sphmg_pkg::*;

   function automatic logic signed [32:0] horner_step(
      input logic signed [32:0] acc,
      input logic [15:0]        x2,
      input logic signed [32:0] coef
   );
      logic signed [49:0] prod;
      prod = acc * $signed({1'b0, x2});
      return coef + prod[47:15];
   endfunction

   logic [14:0]        fold;
   logic [15:0]        xv_in;
   logic [31:0]        sq_in;
   logic signed [49:0] sprod_in;
   logic signed [34:0] rnd;
   logic signed [19:0] trunc;
   logic signed [15:0] mag, sine_in;

   logic [15:0]        xv_ff  [5];
   logic [15:0]        x2_ff  [4];
   logic               neg_ff [6];
   logic signed [32:0] acc_ff [4];
   logic signed [34:0] s_ff;
   logic signed [15:0] sine_ff;

   assign sine = sine_ff;

   always_comb begin
      fold  = phase[14] ? (15'd16384 - {1'b0, phase[13:0]}) : {1'b0, phase[13:0]};
      xv_in = {fold, 1'b0};
      sq_in = xv_in * xv_in;
      sprod_in = acc_ff[3] * $signed({1'b0, xv_ff[4]});
      rnd   = s_ff + 35'sd16384;
      trunc = rnd[34:15];
      if (trunc < 0) mag = 16'sd0;
      else if (trunc > 20'sd32767) mag = 16'sd32767;
      else mag = trunc[15:0];
      sine_in = neg_ff[5] ? -mag : mag;
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         xv_ff[0]  <= xv_in;
         x2_ff[0]  <= sq_in[30:15];
         neg_ff[0] <= phase[15];
         for (int i = 1; i < 5; i++) xv_ff[i] <= xv_ff[i-1];
         for (int i = 1; i < 4; i++) x2_ff[i] <= x2_ff[i-1];
         for (int i = 1; i < 6; i++) neg_ff[i] <= neg_ff[i-1];
         acc_ff[0] <= horner_step(COEF_A9, x2_ff[0], COEF_A7);
         acc_ff[1] <= horner_step(acc_ff[0], x2_ff[1], COEF_A5);
         acc_ff[2] <= horner_step(acc_ff[1], x2_ff[2], COEF_A3);
         acc_ff[3] <= horner_step(acc_ff[2], x2_ff[3], COEF_A1);
         s_ff      <= sprod_in[49:15];
         sine_ff   <= sine_in;
      end
   end

endmodule

>>> sv/sphmg_back.sv
// ----------------------------------------------------------------------------
// Sphere mesh generator back end
// Four sine lanes, vertex products and the output register.
// ----------------------------------------------------------------------------
module sphmg_back (
   input  logic                  clock,
   input  logic                  reset,
   input  sphmg_pkg::entry_type  head,
   input  sphmg_pkg::q_stat_type q_stat,
   output logic                  pop,
   output logic                  out_valid,
   input  logic                  out_ready,
   output logic signed [15:0]    out_x,
   output logic signed [15:0]    out_y,
   output logic signed [15:0]    out_z,
   output sphmg_pkg::side_type   out_side
);
   import sphmg_pkg::*;

   logic                enable;
   logic signed [15:0]  st, ct, sp, cp;
   logic signed [32:0]  xsum_in, ysum_in;

   logic [LANE_LATENCY-1:0] vld_ff;
   side_type            side_ff [LANE_LATENCY];
   logic                out_valid_ff;
   logic signed [15:0]  x_ff, y_ff, z_ff;
   side_type            out_side_ff;

   assign enable    = !out_valid_ff || out_ready;
   assign pop       = enable && !q_stat.empty;
   assign out_valid = out_valid_ff;
   assign out_x     = x_ff;
   assign out_y     = y_ff;
   assign out_z     = z_ff;
   assign out_side  = out_side_ff;

   sphmg_sine u_sin_theta (.clock, .enable, .phase(head.theta), .sine(st));
   sphmg_sine u_cos_theta (.clock, .enable, .phase(head.theta + QUARTER_TURN), .sine(ct));
   sphmg_sine u_sin_phi   (.clock, .enable, .phase(head.phi), .sine(sp));
   sphmg_sine u_cos_phi   (.clock, .enable, .phase(head.phi + QUARTER_TURN), .sine(cp));

   always_comb begin
      xsum_in = st * cp + 33'sd16384;
      ysum_in = st * sp + 33'sd16384;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else if (enable) begin
         vld_ff       <= {vld_ff[LANE_LATENCY-2:0], pop};
         out_valid_ff <= vld_ff[LANE_LATENCY-1];
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         side_ff[0] <= head.side;
         for (int i = 1; i < LANE_LATENCY; i++) side_ff[i] <= side_ff[i-1];
         out_side_ff <= side_ff[LANE_LATENCY-1];
         x_ff <= xsum_in[30:15];
         y_ff <= ysum_in[30:15];
         z_ff <= ct;
      end
   end

endmodule

>>> sv/sphere_mesh_generator.sv
// ----------------------------------------------------------------------------
// Sphere mesh generator
// UV sphere vertex and quad index stream, one grid point per request item.
// ----------------------------------------------------------------------------
// Each request item (req_tdata bit 0: restart) produces one response item:
// the unit vertex in Q1.15 and six triangle indices of the quad starting at
// that grid point, with rsp_tlast on the last point of the mesh.
// The user writes ring count, segment count and the two angle steps via the csr
// channel only while the block is idle (not enforced); csr_ready is always high.
// Throughput: one item per cycle while rsp_tready is high. From request
// acceptance to rsp_tvalid the item is written to the queue, popped from its
// head when the back end is not stalled, then passes the seven-stage polynomial
// sine lanes and the vertex product register.
// A four-entry queue separates the counter front end from the sine back end;
// when rsp_tready is low the back end pipeline holds and the queue fills,
// then req_tready drops.
// Reset clears counters, phases, queue and pipeline valids and loads the
// register defaults (16 rings, 16 segments, steps 2048 and 4096).
// ----------------------------------------------------------------------------
module sphere_mesh_generator #(
   parameter int MAX_RINGS    = 256,
   parameter int MAX_SEGMENTS = 256
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [7:0]                   req_tdata,   // restart
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [151:0]                 rsp_tdata,   // x_coord, y_coord, z_coord,
                                                     // index_a .. index_f
   output logic                         rsp_tlast,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [sphmg_pkg::CSR_IW-1:0] csr_index,
   input  logic [sphmg_pkg::CSR_DW-1:0] csr_data
);
   import sphmg_pkg::*;

`include "sphere_mesh_generator_assert.svh"

   q_stat_type          q_stat;
   logic                push, pop;
   entry_type           push_entry, head;
   logic signed [15:0]  out_x, out_y, out_z;
   side_type            out_side;

   assign csr_ready = 1'b1;

   sphmg_front #(
      .MAX_RINGS(MAX_RINGS),
      .MAX_SEGMENTS(MAX_SEGMENTS)
   ) u_front (
      .clock,
      .reset,
      .req_valid(req_tvalid),
      .restart(req_tdata[0]),
      .req_ready(req_tready),
      .csr_valid,
      .csr_index,
      .csr_data,
      .q_stat,
      .push,
      .push_entry
   );

   sphmg_queue u_queue (
      .clock,
      .reset,
      .push,
      .push_entry,
      .pop,
      .head,
      .q_stat
   );

   sphmg_back u_back (
      .clock,
      .reset,
      .head,
      .q_stat,
      .pop,
      .out_valid(rsp_tvalid),
      .out_ready(rsp_tready),
      .out_x,
      .out_y,
      .out_z,
      .out_side
   );

   assign rsp_tdata = {2'b00, out_side.idx, out_z, out_y, out_x};
   assign rsp_tlast = out_side.done;

   `SMG_ASSERT_SAME(a_stall_no_pop, rsp_tvalid && !rsp_tready, !pop, "pop during output stall")
   `SMG_ASSERT_NEXT(a_push_fills, req_tvalid && req_tready, !q_stat.empty, "queue empty after push")
   `SMG_ASSERT_SAME(a_reset_idle, $past(reset), !rsp_tvalid, "response valid right after reset")

endmodule
